@@ sv/irr_pkg.sv @@
// Shared types and constants for the integer ratio resampler.
// Used by irr_ctrl, irr_dp and integer_ratio_resampler; depends on nothing.
`default_nettype none

package irr_pkg;

    localparam int FACTOR_W = 7;
    localparam int MODE_W   = 2;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_DECIMATE = 2'd0,
        MODE_ZERO_PAD = 2'd1,
        MODE_HOLD     = 2'd2,
        MODE_LINEAR   = 2'd3
    } mode_t;

    localparam mode_t               MODE_RESET   = MODE_HOLD;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 7'd1;

    typedef enum logic {
        REG_MODE   = 1'b0,
        REG_FACTOR = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_EMIT = 2'd2
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic dec_pass;
        logic div_last;
        logic step_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

@@ sv/irr_ctrl.sv @@
// Sequencer: idle, bit-serial divide, emit one result per cycle unless stalled.
// Depends on irr_pkg; drives commands to irr_dp and reads its status.
`default_nettype none

module irr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire irr_pkg::mode_t    mode,
    input  wire irr_pkg::status_t  status,
    output irr_pkg::cmd_t          cmd,
    output logic                   busy
);

    irr_pkg::state_t state_reg;
    irr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= irr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        busy         = 1'b1;
        unique case (state_reg)
            irr_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    priority if (mode == irr_pkg::MODE_LINEAR)
                    begin
                        state_next = irr_pkg::ST_DIV;
                    end
                    else if (mode == irr_pkg::MODE_DECIMATE)
                    begin
                        state_next = status.dec_pass ? irr_pkg::ST_EMIT : irr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = irr_pkg::ST_EMIT;
                    end
                end
            end
            irr_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = irr_pkg::ST_EMIT;
                end
            end
            irr_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.step_last)
                    begin
                        state_next = irr_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = irr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/irr_dp.sv @@
// Datapath: sample and phase state, restoring divider, interpolation
// accumulator and output register. Depends on irr_pkg; driven by irr_ctrl.
`default_nettype none

module irr_dp #(
    parameter int MAX_FACTOR  = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire irr_pkg::cmd_t                 cmd,
    output irr_pkg::status_t                   status,
    input  wire irr_pkg::mode_t                mode,
    input  wire logic [irr_pkg::FACTOR_W-1:0]  factor,
    input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
    input  wire logic                          out_stall,
    output logic                               out_valid,
    output logic signed [SAMPLE_BITS-1:0]      out_sample,
    output logic                               last_of_run
);

    localparam int EFW = $clog2(MAX_FACTOR + 1);
    localparam int PW  = $clog2(MAX_FACTOR);
    localparam int DW  = SAMPLE_BITS + 1;
    localparam int CW  = $clog2(DW);
    localparam int VW  = SAMPLE_BITS + 2;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] base_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic                          neg_reg;
    logic [DW-1:0]                 mag_reg;
    logic [EFW-1:0]                rem_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [EFW-1:0]                f_reg;
    logic [EFW-1:0]                j_reg;
    logic [DW-1:0]                 qacc_reg;
    logic [EFW-1:0]                racc_reg;
    logic [PW-1:0]                 phase_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          last_reg;

    logic [EFW-1:0]                f_eff;
    logic signed [DW-1:0]          diff;
    logic [DW-1:0]                 mag_in;
    logic [EFW-1:0]                phase_inc;
    logic [PW-1:0]                 phase_next;
    logic [EFW:0]                  rem_sh;
    logic                          div_ge;
    logic [EFW-1:0]                rem_next;
    logic [EFW:0]                  r_sum;
    logic                          r_carry;
    logic [EFW-1:0]                racc_next;
    logic [DW-1:0]                 qacc_next;
    logic signed [VW-1:0]          lin_sum;
    logic signed [SAMPLE_BITS-1:0] value_next;
    logic                          step_last;

    always_comb
    begin
        priority if (factor == '0)
        begin
            f_eff = EFW'(1);
        end
        else if (factor > irr_pkg::FACTOR_W'(MAX_FACTOR))
        begin
            f_eff = EFW'(MAX_FACTOR);
        end
        else
        begin
            f_eff = EFW'(factor);
        end
    end

    assign diff   = DW'(in_sample) - DW'(prev_reg);
    assign mag_in = diff[DW-1] ? DW'(-diff) : DW'(diff);

    assign phase_inc  = EFW'(phase_reg) + EFW'(1);
    assign phase_next = (phase_inc >= f_eff) ? '0 : PW'(phase_inc);

    // restoring divide of |diff| by factor, one quotient bit per cycle
    assign rem_sh   = {rem_reg, mag_reg[DW-1]};
    assign div_ge   = rem_sh >= {1'b0, f_reg};
    assign rem_next = div_ge ? EFW'(rem_sh - {1'b0, f_reg}) : rem_sh[EFW-1:0];

    // running floor(|diff|*(j+1)/f) from quotient and remainder
    assign r_sum     = {1'b0, racc_reg} + {1'b0, rem_reg};
    assign r_carry   = r_sum >= {1'b0, f_reg};
    assign racc_next = r_carry ? EFW'(r_sum - {1'b0, f_reg}) : r_sum[EFW-1:0];
    assign qacc_next = qacc_reg + mag_reg + DW'(r_carry);
    assign lin_sum   = neg_reg ? (VW'(base_reg) - VW'({1'b0, qacc_next}))
                               : (VW'(base_reg) + VW'({1'b0, qacc_next}));

    always_comb
    begin
        unique case (mode)
            irr_pkg::MODE_DECIMATE: value_next = x_reg;
            irr_pkg::MODE_ZERO_PAD: value_next = (j_reg == '0) ? x_reg : '0;
            irr_pkg::MODE_HOLD:     value_next = x_reg;
            irr_pkg::MODE_LINEAR:   value_next = SAMPLE_BITS'(lin_sum);
            default:                value_next = x_reg;
        endcase
    end

    assign step_last = (mode == irr_pkg::MODE_DECIMATE) || (j_reg == f_reg - EFW'(1));

    assign status.dec_pass  = (phase_reg == '0);
    assign status.div_last  = (cnt_reg == CW'(DW - 1));
    assign status.step_last = step_last;
    assign status.out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && mode == irr_pkg::MODE_LINEAR)
            begin
                prev_reg <= in_sample;
            end
            if (cmd.load && mode == irr_pkg::MODE_DECIMATE)
            begin
                phase_reg <= phase_next;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= in_sample;
            base_reg <= prev_reg;
            neg_reg  <= diff[DW-1];
            mag_reg  <= mag_in;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            f_reg    <= f_eff;
            j_reg    <= '0;
            qacc_reg <= '0;
            racc_reg <= '0;
        end
        if (cmd.div_step)
        begin
            mag_reg <= {mag_reg[DW-2:0], div_ge};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (cmd.emit)
        begin
            out_sample_reg <= value_next;
            last_reg       <= step_last;
            j_reg          <= j_reg + EFW'(1);
            qacc_reg       <= qacc_next;
            racc_reg       <= racc_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_sample  = out_sample_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

@@ sv/integer_ratio_resampler.sv @@
// Top level of the integer ratio resampler: APB register file, sequencer and datapath.
// Depends on irr_pkg, irr_ctrl and irr_dp.
`default_nettype none

// Resamples signed samples by an integer factor (1 to MAX_FACTOR, 0 reads as 1,
// larger values clamp). One item is taken at a time and results leave one per
// cycle while the output is not stalled, through a single output register.
// Decimate: a dropped item is only loaded, a passed item is loaded and then
// gives its result. Zero-pad and hold: a load, then factor results. Linear: a
// load, the bit-serial divide of the difference, then factor results.
// Set mode and factor only while the block is idle.
module integer_ratio_resampler #(
    parameter int MAX_FACTOR  = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [irr_pkg::APB_AW-1:0]   paddr,
    input  wire logic [irr_pkg::APB_DW-1:0]   pwdata,
    output logic      [irr_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [SAMPLE_BITS-1:0]     out_sample,
    output logic                              last_of_run
);

    irr_pkg::mode_t                 mode_reg;
    logic [irr_pkg::FACTOR_W-1:0]   factor_reg;
    irr_pkg::reg_idx_t              reg_idx;
    logic                           cfg_wr;
    irr_pkg::cmd_t                  cmd;
    irr_pkg::status_t               status;
    logic                           busy;

    assign pready  = 1'b1;
    assign reg_idx = irr_pkg::reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= irr_pkg::MODE_RESET;
            factor_reg <= irr_pkg::FACTOR_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                irr_pkg::REG_MODE:
                begin
                    mode_reg <= irr_pkg::mode_t'(pwdata[irr_pkg::MODE_W-1:0]);
                end
                irr_pkg::REG_FACTOR:
                begin
                    factor_reg <= pwdata[irr_pkg::FACTOR_W-1:0];
                end
                default:
                begin
                    mode_reg <= mode_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            irr_pkg::REG_MODE:   prdata = irr_pkg::APB_DW'(mode_reg);
            irr_pkg::REG_FACTOR: prdata = irr_pkg::APB_DW'(factor_reg);
            default:             prdata = '0;
        endcase
    end

    irr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode_reg),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    irr_dp #(
        .MAX_FACTOR  (MAX_FACTOR),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .mode        (mode_reg),
        .factor      (factor_reg),
        .in_sample   (in_sample),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_sample  (out_sample),
        .last_of_run (last_of_run)
    );

    assign in_stall = busy;

`ifndef SYNTHESIS
    a_dec_single : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mode_reg == irr_pkg::MODE_DECIMATE) |-> last_of_run)
        else $error("decimate result without last_of_run");

    a_unit_factor : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && factor_reg <= irr_pkg::FACTOR_W'(1)) |-> last_of_run)
        else $error("factor one gave more than one result");

    a_busy_after_load : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode_reg != irr_pkg::MODE_DECIMATE) |=> in_stall)
        else $error("input taken again before results were produced");

    a_emit_only_free : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit) |-> (!out_valid || !out_stall))
        else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for integer_ratio_resampler: APB register writes, item stimulus with
// random gaps and output stalls, and a scoreboard fed by an in-bench resampling predictor.
// Depends on irr_pkg and the integer_ratio_resampler RTL.
module tb_top;

    localparam int SAMPLE_BITS  = 24;
    localparam int MAX_FACTOR   = 64;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 128;
    localparam int RANDOM_ITEMS = 360;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef struct {
        sample_t sample;
        logic    last;
    } resampled_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [irr_pkg::APB_AW-1:0]   paddr;
    logic [irr_pkg::APB_DW-1:0]   pwdata;
    logic [irr_pkg::APB_DW-1:0]   prdata;
    logic                         pready;
    logic                         in_valid;
    logic                         in_stall;
    sample_t                      in_sample;
    logic                         out_valid;
    logic                         out_stall;
    sample_t                      out_sample;
    logic                         last_of_run;

    resampled_t                   resampled_q[$];
    irr_pkg::mode_t               cur_mode;
    logic [irr_pkg::FACTOR_W-1:0] cur_factor;
    sample_t                      prev_sample;
    logic [5:0]                   dec_phase;

    int                           fail_count;
    bit                           tx_quiet;
    bit                           rx_quiet;
    int                           rx_hold_cycles;

    integer_ratio_resampler #(
        .MAX_FACTOR  (MAX_FACTOR),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_sample   (in_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_sample  (out_sample),
        .last_of_run (last_of_run)
    );

    always #1 clk = ~clk;

    function automatic int active_factor();
        if (cur_factor == 0)
            return 1;
        if (cur_factor > MAX_FACTOR)
            return MAX_FACTOR;
        return int'(cur_factor);
    endfunction

    task automatic resample_item(input sample_t x);
        int         f;
        longint     diff;
        longint     v;
        resampled_t r;
        f = active_factor();
        if (cur_mode == irr_pkg::MODE_DECIMATE)
        begin
            if (dec_phase == 0)
            begin
                r.sample = x;
                r.last   = 1'b1;
                resampled_q.push_back(r);
            end
            if (int'(dec_phase) + 1 >= f)
                dec_phase = '0;
            else
                dec_phase = dec_phase + 6'd1;
        end
        else
        begin
            for (int j = 0; j < f; j++)
            begin
                case (cur_mode)
                    irr_pkg::MODE_ZERO_PAD: v = (j == 0) ? longint'(x) : 0;
                    irr_pkg::MODE_HOLD:     v = longint'(x);
                    default:
                    begin
                        diff = longint'(x) - longint'(prev_sample);
                        v    = longint'(prev_sample) + (diff * longint'(j + 1)) / longint'(f);
                    end
                endcase
                r.sample = sample_t'(v);
                r.last   = (j + 1 == f);
                resampled_q.push_back(r);
            end
            if (cur_mode == irr_pkg::MODE_LINEAR)
                prev_sample = x;
        end
    endtask

    // wait for the block to go idle; decimate items may leave no result behind
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (resampled_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input irr_pkg::reg_idx_t idx,
                             input logic [irr_pkg::APB_DW-1:0] value);
        settle();
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == irr_pkg::REG_MODE)
            cur_mode = irr_pkg::mode_t'(value[irr_pkg::MODE_W-1:0]);
        else
            cur_factor = value[irr_pkg::FACTOR_W-1:0];
    endtask

    task automatic send_item(input sample_t x);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        in_sample = x;
        do @(posedge clk); while (in_stall);
        resample_item(x);
    endtask

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return sample_t'(int'($urandom_range(0, 31)) - 16);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic logic [irr_pkg::APB_DW-1:0] rand_factor();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return MAX_FACTOR;
            2:       return $urandom_range(MAX_FACTOR + 1, 127);
            3:       return $urandom_range(9, MAX_FACTOR - 1);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    // junk in the upper data bits must be ignored
    function automatic logic [irr_pkg::APB_DW-1:0] with_junk(
        input logic [irr_pkg::APB_DW-1:0] value, input int w);
        logic [irr_pkg::APB_DW-1:0] junk;
        junk = $urandom;
        return (junk << w) | value;
    endfunction

    task automatic test_reset_defaults();
        send_item('0);
        send_item(SAMPLE_MAX);
        send_item(SAMPLE_MIN);
    endtask

    task automatic test_pad_and_hold();
        write_reg(irr_pkg::REG_FACTOR, 3);
        write_reg(irr_pkg::REG_MODE, with_junk(irr_pkg::MODE_ZERO_PAD, irr_pkg::MODE_W));
        send_item(SAMPLE_MAX);
        send_item(SAMPLE_MIN);
        write_reg(irr_pkg::REG_MODE, irr_pkg::MODE_HOLD);
        send_item('1);
    endtask

    task automatic test_linear();
        write_reg(irr_pkg::REG_MODE, irr_pkg::MODE_LINEAR);
        write_reg(irr_pkg::REG_FACTOR, 127);
        send_item(SAMPLE_MAX);
        send_item(SAMPLE_MIN);
        send_item(SAMPLE_MAX);
        write_reg(irr_pkg::REG_FACTOR, 0);
        send_item(SAMPLE_MIN);
        send_item(sample_t'(5));
        write_reg(irr_pkg::REG_FACTOR, with_junk(7, irr_pkg::FACTOR_W));
        send_item(sample_t'(-7));
        send_item(sample_t'(7));
    endtask

    // phase left past a shrunken factor drops one item and wraps
    task automatic test_decimate_phase();
        write_reg(irr_pkg::REG_MODE, irr_pkg::MODE_DECIMATE);
        write_reg(irr_pkg::REG_FACTOR, 8);
        for (int i = 0; i < 3; i++)
            send_item(rand_sample());
        write_reg(irr_pkg::REG_FACTOR, 2);
        for (int i = 0; i < 3; i++)
            send_item(rand_sample());
        write_reg(irr_pkg::REG_FACTOR, 1);
        send_item(SAMPLE_MAX);
        send_item(SAMPLE_MIN);
    endtask

    task automatic test_backpressure();
        write_reg(irr_pkg::REG_MODE, irr_pkg::MODE_HOLD);
        write_reg(irr_pkg::REG_FACTOR, 16);
        tx_quiet       = 1'b1;
        rx_hold_cycles = 300;
        for (int i = 0; i < 4; i++)
            send_item(rand_sample());
        tx_quiet = 1'b0;
        settle();
    endtask

    task automatic test_random();
        int sent;
        int n;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 1))
            begin
                write_reg(irr_pkg::REG_MODE, with_junk($urandom_range(0, 3), irr_pkg::MODE_W));
                write_reg(irr_pkg::REG_FACTOR, with_junk(rand_factor(), irr_pkg::FACTOR_W));
            end
            else
            begin
                write_reg(irr_pkg::REG_FACTOR, with_junk(rand_factor(), irr_pkg::FACTOR_W));
                write_reg(irr_pkg::REG_MODE, with_junk($urandom_range(0, 3), irr_pkg::MODE_W));
            end
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            n = $urandom_range(20, 50);
            for (int i = 0; i < n; i++)
                send_item(rand_sample());
            sent += n;
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        in_sample      = '0;
        cur_mode       = irr_pkg::MODE_RESET;
        cur_factor     = irr_pkg::FACTOR_RESET;
        prev_sample    = '0;
        dec_phase      = '0;
        fail_count     = 0;
        tx_quiet       = 1'b0;
        rx_quiet       = 1'b0;
        rx_hold_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_pad_and_hold();
        test_linear();
        test_decimate_phase();
        test_backpressure();
        test_random();
        settle();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // output side: random stall per item, plus an occasional long hold-off
    initial
    begin
        int gap;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_stall = 1'b1;
                repeat (rx_hold_cycles) @(negedge clk);
                rx_hold_cycles = 0;
            end
            gap = rx_quiet ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                out_stall = 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        resampled_t exp_item;
        if (rst_n && out_valid && !out_stall)
        begin
            if (resampled_q.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, actual sample %0d last %0b",
                         $time, out_sample, last_of_run);
                fail_count++;
            end
            else
            begin
                exp_item = resampled_q.pop_front();
                if (out_sample !== exp_item.sample)
                begin
                    $display("%0t: out_sample mismatch: expected %0d, actual %0d",
                             $time, exp_item.sample, out_sample);
                    fail_count++;
                end
                if (last_of_run !== exp_item.last)
                begin
                    $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                             $time, exp_item.last, last_of_run);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: timeout with %0d items outstanding", $time, resampled_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
